// ===== rtl/lhr_pkg.sv =====
// ----------------------------------------------------------------------------
// lhr_pkg
// Shared types and constants of the largest histogram rectangle unit.
// ----------------------------------------------------------------------------
package lhr_pkg;

	localparam int HEIGHT_W = 16;
	localparam int AREA_W   = 26;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_LOAD,
		ST_FLUSH,
		ST_FLOAD,
		ST_DRAIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic push;
		logic pop;
		logic load_top;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic depth_zero;
		logic depth_one;
		logic top_ge;
		logic cur_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/lhr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhr_ctrl
// Sequencer for bar acceptance, stack pops and pushes, flush and result.
// ----------------------------------------------------------------------------
module lhr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_bar,
	output logic           in_stall,
	input  lhr_pkg::sts_t  sts,
	output lhr_pkg::cmd_t  cmd
);

	lhr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lhr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					// A bar beyond the capacity is dropped, but its last flag still counts.
					if (!sts.full) begin
						state_d = lhr_pkg::ST_CMP;
					end else if (last_bar) begin
						state_d = lhr_pkg::ST_FLUSH;
					end
				end
			end
			lhr_pkg::ST_CMP: begin
				if (!sts.depth_zero && sts.top_ge) begin
					cmd.pop = 1'b1;
					state_d = sts.depth_one ? lhr_pkg::ST_CMP : lhr_pkg::ST_LOAD;
				end else begin
					cmd.push = 1'b1;
					state_d = sts.cur_last ? lhr_pkg::ST_FLUSH : lhr_pkg::ST_IDLE;
				end
			end
			lhr_pkg::ST_LOAD: begin
				cmd.load_top = 1'b1;
				state_d      = lhr_pkg::ST_CMP;
			end
			lhr_pkg::ST_FLUSH: begin
				if (sts.depth_zero) begin
					state_d = lhr_pkg::ST_DRAIN;
				end else begin
					cmd.pop = 1'b1;
					state_d = sts.depth_one ? lhr_pkg::ST_FLUSH : lhr_pkg::ST_FLOAD;
				end
			end
			lhr_pkg::ST_FLOAD: begin
				cmd.load_top = 1'b1;
				state_d      = lhr_pkg::ST_FLUSH;
			end
			lhr_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = lhr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lhr_dp.sv =====
// ----------------------------------------------------------------------------
// lhr_dp
// Stack memory, top-of-stack registers, area scoring pipeline and result
// register.
// ----------------------------------------------------------------------------
module lhr_dp #(
	parameter int MAX_BARS    = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lhr_pkg::HEIGHT_W-1:0] bar_height,
	input  logic                         last_bar,
	input  lhr_pkg::cmd_t                cmd,
	output lhr_pkg::sts_t                sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lhr_pkg::AREA_W-1:0]   max_area,
	output logic                         overflow
);

	localparam int HW = (HEIGHT_BITS < lhr_pkg::HEIGHT_W) ? HEIGHT_BITS : lhr_pkg::HEIGHT_W;
	localparam int IW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int DW = $clog2(MAX_BARS + 1);
	localparam int PW = HW + DW;
	localparam int XW = (PW > lhr_pkg::AREA_W) ? PW : lhr_pkg::AREA_W;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] bar_idx_q;
	logic [lhr_pkg::AREA_W-1:0] best_q;
	logic ovf_q;

	logic [HW-1:0] cur_h_q;
	logic [IW-1:0] cur_start_q;
	logic          cur_last_q;
	logic [HW-1:0] top_h_q;
	logic [IW-1:0] top_s_q;

	logic [HW+IW-1:0] mem [MAX_BARS];
	logic [HW+IW-1:0] rd_q;
	logic [DW-1:0]    depth_m1;
	logic [DW-1:0]    depth_m2;
	logic [IW-1:0]    wr_addr;
	logic [IW-1:0]    rd_addr;
	logic             wr_en;

	logic          s1_valid_q, s2_valid_q;
	logic [HW-1:0] h_s1;
	logic [DW-1:0] w_s1;
	logic [XW-1:0] prod_s2;
	logic [lhr_pkg::AREA_W-1:0] area_sat;

	logic          out_valid_q;
	logic [lhr_pkg::AREA_W-1:0] max_area_q;
	logic          overflow_q;

	assign sts.full       = (bar_idx_q == DW'(MAX_BARS));
	assign sts.depth_zero = (depth_q == '0);
	assign sts.depth_one  = (depth_q == DW'(1));
	assign sts.top_ge     = (top_h_q >= cur_h_q);
	assign sts.cur_last   = cur_last_q;
	assign sts.pipe_busy  = s1_valid_q | s2_valid_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	// The top entry lives in registers; the memory holds the entries below it.
	assign wr_en    = cmd.push && (depth_q != '0);
	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign wr_addr  = depth_m1[IW-1:0];
	assign rd_addr  = depth_m2[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {top_h_q, top_s_q};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_h_q     <= bar_height[HW-1:0];
			cur_start_q <= bar_idx_q[IW-1:0];
			cur_last_q  <= last_bar;
		end else if (cmd.pop) begin
			cur_start_q <= top_s_q;
		end
		if (cmd.push) begin
			top_h_q <= cur_h_q;
			top_s_q <= cur_start_q;
		end else if (cmd.load_top) begin
			top_h_q <= rd_q[HW+IW-1:IW];
			top_s_q <= rd_q[IW-1:0];
		end
		if (cmd.pop) begin
			h_s1 <= top_h_q;
			w_s1 <= bar_idx_q - DW'(top_s_q);
		end
		if (s1_valid_q) begin
			prod_s2 <= XW'(h_s1) * XW'(w_s1);
		end
		if (cmd.emit) begin
			max_area_q <= best_q;
			overflow_q <= ovf_q;
		end
	end

	assign area_sat = (prod_s2 > XW'(lhr_pkg::AREA_MAX)) ? lhr_pkg::AREA_MAX
	                                                     : prod_s2[lhr_pkg::AREA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			bar_idx_q   <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= cmd.pop;
			s2_valid_q <= s1_valid_q;
			if (cmd.emit) begin
				depth_q   <= '0;
				bar_idx_q <= '0;
				best_q    <= '0;
				ovf_q     <= 1'b0;
			end else begin
				if (cmd.accept && sts.full) begin
					ovf_q <= 1'b1;
				end
				if (cmd.push) begin
					depth_q   <= depth_q + DW'(1);
					bar_idx_q <= bar_idx_q + DW'(1);
				end else if (cmd.pop) begin
					depth_q <= depth_q - DW'(1);
				end
				if (s2_valid_q && (area_sat > best_q)) begin
					best_q <= area_sat;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign max_area  = max_area_q;
	assign overflow  = overflow_q;

`ifndef SYNTH
	a_depth_le_index: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= bar_idx_q)
		else $error("stack holds more entries than bars accepted");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bar_idx_q <= DW'(MAX_BARS))
		else $error("bar count beyond capacity");
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!s1_valid_q && !s2_valid_q && depth_q == '0))
		else $error("result taken before scoring finished");
	a_push_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (depth_q == '0 || top_h_q < cur_h_q))
		else $error("push would break stack order");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop from empty stack");
`endif

endmodule

// ===== rtl/largest_histogram_rectangle_unit.sv =====
// ----------------------------------------------------------------------------
// largest_histogram_rectangle_unit
// Largest rectangle under a histogram with a monotonic stack.
// ----------------------------------------------------------------------------
// Bars enter one per item, left to right; the item with last_bar set closes
// the histogram and one result follows with the largest area and the
// overflow flag. A bar is compared with the stack top and then pushed, and
// every stack entry it pops first adds a step to score it and a step to
// reload the next top from the stack memory with its registered read (the
// reload is skipped when the stack empties). The last bar then flushes the
// stack with the same score and reload steps per entry and waits for the
// scoring multiplier pipeline to empty and the output register to be free
// before the result is registered. Every accepted bar is pushed once and
// popped once over a whole histogram. Bars beyond MAX_BARS are dropped and
// set the overflow flag. A finished result waits in an output register
// while the next histogram is taken in.
// ----------------------------------------------------------------------------
module largest_histogram_rectangle_unit #(
	parameter int MAX_BARS    = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lhr_pkg::HEIGHT_W-1:0] bar_height,
	input  logic                         last_bar,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lhr_pkg::AREA_W-1:0]   max_area,
	output logic                         overflow
);

	lhr_pkg::cmd_t cmd;
	lhr_pkg::sts_t sts;

	lhr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_bar (last_bar),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhr_dp #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.bar_height (bar_height),
		.last_bar   (last_bar),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.max_area   (max_area),
		.overflow   (overflow)
	);

endmodule

// ===== dv/largest_histogram_rectangle_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_histogram_rectangle_unit_tb
// Self-checking bench for the largest histogram rectangle unit.
// ----------------------------------------------------------------------------
// Histograms are streamed bar by bar through the input channel. A stack-based
// predictor scores every accepted bar and queues the area and overflow flag
// that each closing bar must produce; the output side compares every result
// with the oldest queued one. Three phases vary the idling of both sides, and
// one histogram runs past the bar limit with a stack filled to full depth.
// ----------------------------------------------------------------------------
module largest_histogram_rectangle_unit_tb;

	localparam int MAX_BARS = 1024;

	typedef struct packed {
		logic [lhr_pkg::HEIGHT_W-1:0] height;
		logic                         last;
	} bar_t;

	typedef struct packed {
		logic [lhr_pkg::AREA_W-1:0] area;
		logic                       ovf;
	} area_rec_t;

	typedef enum int {
		SHAPE_RANDOM,
		SHAPE_LOW,
		SHAPE_RISING,
		SHAPE_FALLING,
		SHAPE_HIGH
	} shape_t;

	logic                         clk;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [lhr_pkg::HEIGHT_W-1:0] bar_height = '0;
	logic                         last_bar   = 1'b0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic [lhr_pkg::AREA_W-1:0]   max_area;
	logic                         overflow;

	bar_t      bar_queue[$];
	area_rec_t area_expect[$];
	bar_t      next_bar;
	area_rec_t got_expect;

	int unsigned send_idle_pct = 25;
	int unsigned recv_stall_pct = 71;

	// Predictor state.
	logic [lhr_pkg::HEIGHT_W-1:0] rect_height[MAX_BARS];
	int unsigned                  rect_start[MAX_BARS];
	int unsigned                  rect_depth = 0;
	int unsigned                  rect_bars = 0;
	logic [lhr_pkg::AREA_W-1:0]   rect_best = '0;
	logic                         rect_dropped = 1'b0;

	int unsigned bars_queued = 0;
	int unsigned histograms_queued = 0;
	int unsigned bars_taken = 0;
	int unsigned results_checked = 0;
	int unsigned overflow_results = 0;
	int unsigned mismatches = 0;

	largest_histogram_rectangle_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.bar_height (bar_height),
		.last_bar   (last_bar),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.max_area   (max_area),
		.overflow   (overflow)
	);

	task automatic rect_score(input logic [lhr_pkg::HEIGHT_W-1:0] h, input int unsigned w);
		longint unsigned a;
		a = longint'(h) * longint'(w);
		if (a > longint'(lhr_pkg::AREA_MAX))
			a = longint'(lhr_pkg::AREA_MAX);
		if (a > rect_best)
			rect_best = a[lhr_pkg::AREA_W-1:0];
	endtask

	task automatic rect_take_bar(input bar_t b);
		int unsigned first;
		if (rect_bars < MAX_BARS) begin
			first = rect_bars;
			while (rect_depth > 0 && rect_height[rect_depth-1] >= b.height) begin
				rect_depth--;
				rect_score(rect_height[rect_depth], rect_bars - rect_start[rect_depth]);
				first = rect_start[rect_depth];
			end
			rect_height[rect_depth] = b.height;
			rect_start[rect_depth]  = first;
			rect_depth++;
			rect_bars++;
		end else begin
			rect_dropped = 1'b1;
		end
		if (b.last) begin
			while (rect_depth > 0) begin
				rect_depth--;
				rect_score(rect_height[rect_depth], rect_bars - rect_start[rect_depth]);
			end
			area_expect.push_back('{area: rect_best, ovf: rect_dropped});
			rect_bars    = 0;
			rect_best    = '0;
			rect_dropped = 1'b0;
		end
	endtask

	task automatic queue_bar(input int unsigned h, input bit last);
		bar_queue.push_back('{height: h[lhr_pkg::HEIGHT_W-1:0], last: last});
		bars_queued++;
		if (last)
			histograms_queued++;
	endtask

	task automatic queue_histogram(input int unsigned len, input shape_t shape);
		int unsigned h;
		h = (shape == SHAPE_FALLING) ? 65535 : $urandom_range(40);
		for (int unsigned i = 0; i < len; i++) begin
			case (shape)
				SHAPE_RANDOM:  h = $urandom_range(65535);
				SHAPE_LOW:     h = $urandom_range(3);
				SHAPE_RISING:  h = (h + $urandom_range(2000) > 65535) ? 65535 :
						h + $urandom_range(2000);
				SHAPE_FALLING: h = (h < 2000) ? $urandom_range(h) : h - $urandom_range(2000);
				default:       h = 65535 - $urandom_range(7);
			endcase
			queue_bar(h, i == len - 1);
		end
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned goal;
		goal = bars_queued + count;
		while (bars_queued < goal)
			queue_histogram(($urandom_range(8) == 0) ? $urandom_range(60, 13) :
					$urandom_range(12, 1), shape_t'($urandom_range(4)));
	endtask

	// The sender stops here until every expected result has come back.
	task automatic drain_all();
		while (bar_queue.size() != 0 || in_valid || area_expect.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Input side: predicts each accepted item, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rect_take_bar('{height: bar_height, last: last_bar});
				bars_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (bar_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_bar = bar_queue.pop_front();
					in_valid   <= 1'b1;
					bar_height <= next_bar.height;
					last_bar   <= next_bar.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (area_expect.size() == 0) begin
					$display("%0t: expected no result, got max_area %0d overflow %0b",
						$time, max_area, overflow);
					mismatches++;
				end else begin
					got_expect = area_expect.pop_front();
					if (max_area !== got_expect.area) begin
						$display("%0t: max_area expected %0d, got %0d",
							$time, got_expect.area, max_area);
						mismatches++;
					end
					if (overflow !== got_expect.ovf) begin
						$display("%0t: overflow expected %0b, got %0b",
							$time, got_expect.ovf, overflow);
						mismatches++;
					end
					if (got_expect.ovf)
						overflow_results++;
					results_checked++;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		// Single bars at both height extremes, then small known shapes.
		queue_bar(0, 1);
		queue_bar(65535, 1);
		queue_bar(65535, 0);
		queue_bar(65535, 1);
		queue_bar(2, 0);
		queue_bar(1, 0);
		queue_bar(5, 0);
		queue_bar(6, 0);
		queue_bar(2, 0);
		queue_bar(3, 1);
		queue_bar(5, 0);
		queue_bar(5, 0);
		queue_bar(5, 1);
		queue_bar(16'hAAAA, 0);
		queue_bar(16'h5555, 0);
		queue_bar(0, 0);
		queue_bar(65535, 1);
		for (int i = 1; i <= 4; i++)
			queue_bar(i, i == 4);
		for (int i = 4; i >= 1; i--)
			queue_bar(i, i == 1);
		queue_random(175);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		drain_all();

		send_idle_pct  = 71;
		recv_stall_pct = 25;
		queue_random(100);
		// Strictly rising bars fill the stack to full depth; the three bars
		// past the limit are dropped, and the last of them closes the histogram.
		for (int unsigned i = 0; i < MAX_BARS + 3; i++)
			queue_bar((i < MAX_BARS) ? i * 64 + $urandom_range(63) : $urandom_range(65535),
				i == MAX_BARS + 2);
		queue_random(100);
		drain_all();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(175);
		drain_all();
		repeat (30) @(posedge clk);

		$display("Covered %0d bars in %0d histograms under three idling mixes.",
			bars_taken, histograms_queued);
		$display("Checked %0d results, %0d with dropped bars; mismatches found: %0d.",
			results_checked, overflow_results, mismatches);
		if (mismatches == 0 && area_expect.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
